FILE: src/hsv_pkg.sv
// Shared types and constants for the HSV to RGB color converter.
`default_nettype none

package hsv_pkg;

    // Sector of the hue circle, sixths of a full turn.
    localparam int SECTOR_W = 3;
    typedef logic [SECTOR_W-1:0] sector_t;

    localparam sector_t SECTOR_RED_YELLOW    = 3'd0;
    localparam sector_t SECTOR_YELLOW_GREEN  = 3'd1;
    localparam sector_t SECTOR_GREEN_CYAN    = 3'd2;
    localparam sector_t SECTOR_CYAN_BLUE     = 3'd3;
    localparam sector_t SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam sector_t SECTOR_MAGENTA_RED   = 3'd5;

    // Side information that travels with a pixel next to the level pipelines.
    typedef struct packed {
        sector_t sector;
        logic    grey;
    } side_t;

endpackage

`default_nettype wire

FILE: src/hsv_sector.sv
// Hue stage: splits the hue into its sector and the fraction within it.
`default_nettype none

module hsv_sector #(
    parameter int HUE_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [HUE_BITS-1:0]   hue,
    output hsv_pkg::sector_t           sector,
    output logic      [HUE_BITS-1:0]   frac
);

    localparam int H6_W = HUE_BITS + hsv_pkg::SECTOR_W;

    logic [H6_W-1:0]      h6;
    hsv_pkg::sector_t     sector_reg;
    logic [HUE_BITS-1:0]  frac_reg;

    // hue * 6 as two shifted copies; the top three bits are the sector.
    assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            sector_reg <= h6[H6_W-1:HUE_BITS];
            frac_reg   <= h6[HUE_BITS-1:0];
        end
    end

    assign sector = sector_reg;
    assign frac   = frac_reg;

endmodule

`default_nettype wire

FILE: src/hsv_level.sv
// Level pipeline: brightness * (1 - s*w) rounded to nearest, in three stages.
`default_nettype none

module hsv_level #(
    parameter int HUE_BITS     = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [CHANNEL_BITS-1:0]   sat,
    input  wire logic [CHANNEL_BITS-1:0]   val,
    input  wire logic [HUE_BITS:0]         weight,
    output logic      [CHANNEL_BITS-1:0]   level
);

    localparam int C    = CHANNEL_BITS;
    localparam int PW   = CHANNEL_BITS + HUE_BITS + 1;
    localparam int DW   = CHANNEL_BITS + HUE_BITS;
    localparam int XW   = 2 * CHANNEL_BITS + HUE_BITS;
    localparam int YW   = 2 * CHANNEL_BITS;
    localparam logic [C-1:0]  MAXV     = {C{1'b1}};
    localparam logic [PW-1:0] ONE_FULL = {1'b0, MAXV, {HUE_BITS{1'b0}}};
    localparam logic [XW-1:0] HALF     = {{(C+1){1'b0}}, MAXV, {(HUE_BITS-1){1'b0}}};

    logic [PW-1:0] prod;
    logic [DW-1:0] diff_next, diff_reg;
    logic [C-1:0]  val_a_reg;
    logic [XW-1:0] scaled;
    logic [YW-1:0] quo_next, quo_reg;
    logic [C-1:0]  hi_part, lo_part;
    logic [C:0]    part_sum;
    logic [C-1:0]  level_next, level_reg;

    // Stage A: numerator of the level, M*2^H - sat*weight, never negative.
    assign prod      = PW'(sat * weight);
    assign diff_next = DW'(ONE_FULL - prod);

    // Stage B: times brightness, plus half the denominator, divided by 2^H.
    assign scaled   = XW'(val_a_reg * diff_reg) + HALF;
    assign quo_next = scaled[XW-1:HUE_BITS];

    // Stage C: divide by M = 2^C - 1. With y = a*2^C + b we have y = a*M + (a+b),
    // and a+b is at most 2*M, so at most two corrections are needed.
    assign hi_part  = quo_reg[YW-1:C];
    assign lo_part  = quo_reg[C-1:0];
    assign part_sum = {1'b0, hi_part} + {1'b0, lo_part};

    always_comb begin
        priority if (part_sum >= {MAXV, 1'b0}) begin
            level_next = hi_part + C'(2);
        end else if (part_sum >= {1'b0, MAXV}) begin
            level_next = hi_part + C'(1);
        end else begin
            level_next = hi_part;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg  <= diff_next;
            val_a_reg <= val;
            quo_reg   <= quo_next;
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

FILE: src/hsv_to_rgb.sv
// Five register stages lie between an input transfer and the result on m_* (no
// stall). Throughput: one pixel per clock cycle while m_ready does not hold the output; the whole pipeline
// advances together. Each of the three levels has its own multiply / multiply /
// divide-by-M chain.
// Reset: synchronous, active low aresetn clears every stage valid bit; no other state.
// A stalled result holds the whole pipeline in place, so nothing is lost or repeated.
`default_nettype none

module hsv_to_rgb #(
    parameter int HUE_BITS     = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Input channel: one HSV pixel per transfer.
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [HUE_BITS-1:0]       s_hue,
    input  wire logic [CHANNEL_BITS-1:0]   s_saturation,
    input  wire logic [CHANNEL_BITS-1:0]   s_brightness,
    // Result channel: one RGB pixel per transfer.
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic      [CHANNEL_BITS-1:0]   m_red,
    output logic      [CHANNEL_BITS-1:0]   m_green,
    output logic      [CHANNEL_BITS-1:0]   m_blue
);

    localparam int C         = CHANNEL_BITS;
    // Stages between the hue stage and the output register, one per level stage.
    localparam int LEV_DEPTH = 3;

    // The pipeline moves when the output register is empty or being drained.
    logic en;

    // Stage 1: sector and fraction, plus the saturation and brightness beside them.
    hsv_pkg::sector_t     sector1;
    logic [HUE_BITS-1:0]  frac1;
    logic [C-1:0]         sat1_reg;
    logic [C-1:0]         val1_reg;
    logic                 valid1_reg;

    // Weights for the three levels: p uses a full turn, q the fraction,
    // t the rest of the sector.
    logic [HUE_BITS:0]    w_p, w_q, w_t;
    logic [C-1:0]         lev_p, lev_q, lev_t;

    // Side pipeline that stays in step with the level pipelines.
    hsv_pkg::side_t       side_next;
    hsv_pkg::side_t       side_reg  [LEV_DEPTH];
    logic [C-1:0]         val_reg   [LEV_DEPTH];
    logic [LEV_DEPTH-1:0] valid_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [C-1:0]         red_next, green_next, blue_next;
    logic [C-1:0]         red_reg, green_reg, blue_reg;
    logic [C-1:0]         v_out;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    hsv_sector #(
        .HUE_BITS (HUE_BITS)
    ) u_sector (
        .aclk   (aclk),
        .en     (en),
        .hue    (s_hue),
        .sector (sector1),
        .frac   (frac1)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sat1_reg <= s_saturation;
            val1_reg <= s_brightness;
        end
    end

    assign w_p = {1'b1, {HUE_BITS{1'b0}}};
    assign w_q = {1'b0, frac1};
    assign w_t = w_p - {1'b0, frac1};

    hsv_level #(
        .HUE_BITS     (HUE_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_level_p (
        .aclk   (aclk),
        .en     (en),
        .sat    (sat1_reg),
        .val    (val1_reg),
        .weight (w_p),
        .level  (lev_p)
    );

    hsv_level #(
        .HUE_BITS     (HUE_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_level_q (
        .aclk   (aclk),
        .en     (en),
        .sat    (sat1_reg),
        .val    (val1_reg),
        .weight (w_q),
        .level  (lev_q)
    );

    hsv_level #(
        .HUE_BITS     (HUE_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_level_t (
        .aclk   (aclk),
        .en     (en),
        .sat    (sat1_reg),
        .val    (val1_reg),
        .weight (w_t),
        .level  (lev_t)
    );

    // Zero saturation is pure grey and bypasses the levels at the output mux.
    assign side_next.sector = sector1;
    assign side_next.grey   = (sat1_reg == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            val_reg[0]  <= val1_reg;
            for (int i = 1; i < LEV_DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
                val_reg[i]  <= val_reg[i-1];
            end
        end
    end

    // Channel order chosen by the sector of the last level stage.
    assign v_out = val_reg[LEV_DEPTH-1];

    always_comb begin
        red_next   = v_out;
        green_next = v_out;
        blue_next  = v_out;
        if (!side_reg[LEV_DEPTH-1].grey) begin
            unique case (side_reg[LEV_DEPTH-1].sector)
                hsv_pkg::SECTOR_RED_YELLOW: begin
                    red_next = v_out; green_next = lev_t; blue_next = lev_p;
                end
                hsv_pkg::SECTOR_YELLOW_GREEN: begin
                    red_next = lev_q; green_next = v_out; blue_next = lev_p;
                end
                hsv_pkg::SECTOR_GREEN_CYAN: begin
                    red_next = lev_p; green_next = v_out; blue_next = lev_t;
                end
                hsv_pkg::SECTOR_CYAN_BLUE: begin
                    red_next = lev_p; green_next = lev_q; blue_next = v_out;
                end
                hsv_pkg::SECTOR_BLUE_MAGENTA: begin
                    red_next = lev_t; green_next = lev_p; blue_next = v_out;
                end
                default: begin
                    red_next = v_out; green_next = lev_p; blue_next = lev_q;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // Valid bits follow the data through every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg  <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            valid1_reg  <= s_valid;
            valid_reg   <= {valid_reg[LEV_DEPTH-2:0], valid1_reg};
            m_valid_reg <= valid_reg[LEV_DEPTH-1];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

    // A grey pixel leaving the last level stage shows up with three equal channels.
    a_grey_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && valid_reg[LEV_DEPTH-1] && side_reg[LEV_DEPTH-1].grey)
        |=> (m_red == m_green && m_green == m_blue))
        else $error("grey pixel produced unequal channels");

    // The divide-by-M correction never lets a level exceed the brightness.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LEV_DEPTH-1]
        |-> (lev_p <= v_out && lev_q <= v_out && lev_t <= v_out))
        else $error("level above brightness");

    // While the output is stalled, the valid bits inside the pipeline hold.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg) && $stable(valid1_reg))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

FILE: tb/hsv_rgb_checker.sv
// Checker for the HSV to RGB converter: predicts every accepted pixel and compares the results.
module hsv_rgb_checker #(
    parameter int HUE_BITS     = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    input  wire logic                    s_ready,
    input  wire logic [HUE_BITS-1:0]     s_hue,
    input  wire logic [CHANNEL_BITS-1:0] s_saturation,
    input  wire logic [CHANNEL_BITS-1:0] s_brightness,
    input  wire logic                    m_valid,
    input  wire logic                    m_ready,
    input  wire logic [CHANNEL_BITS-1:0] m_red,
    input  wire logic [CHANNEL_BITS-1:0] m_green,
    input  wire logic [CHANNEL_BITS-1:0] m_blue,
    output int                           mismatch_count,
    output int                           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [63:0] HUE_ONE = 64'd1 << HUE_BITS;
    localparam bit [63:0] CH_MAX  = (64'd1 << CHANNEL_BITS) - 64'd1;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_t;

    rgb_t expected_rgb[$];

    // Brightness scaled by num/den, rounded to nearest with ties up, clamped to full scale.
    function automatic bit [63:0] round_level(input bit [63:0] level, input bit [63:0] num,
                                              input bit [63:0] den);
        bit [63:0] scaled;
        scaled = (level * num + den / 64'd2) / den;
        return (scaled > CH_MAX) ? CH_MAX : scaled;
    endfunction

    function automatic rgb_t convert_pixel(input logic [HUE_BITS-1:0] hue,
                                           input logic [CHANNEL_BITS-1:0] sat,
                                           input logic [CHANNEL_BITS-1:0] bri);
        bit [63:0]        h6, frac, den, v, s, lp, lq, lt;
        hsv_pkg::sector_t sector;
        rgb_t             px;
        v = bri;
        s = sat;
        if (s == 64'd0) begin
            px.red   = bri;
            px.green = bri;
            px.blue  = bri;
            return px;
        end
        h6     = hue;
        h6     = h6 * 64'd6;
        sector = hsv_pkg::sector_t'(h6 >> HUE_BITS);
        frac   = h6 & (HUE_ONE - 64'd1);
        den    = CH_MAX * HUE_ONE;
        lp     = round_level(v, (CH_MAX - s) * HUE_ONE, den);
        lq     = round_level(v, den - s * frac, den);
        lt     = round_level(v, den - s * (HUE_ONE - frac), den);
        case (sector)
            hsv_pkg::SECTOR_RED_YELLOW: begin
                px.red = v[CHANNEL_BITS-1:0];  px.green = lt[CHANNEL_BITS-1:0];
                px.blue = lp[CHANNEL_BITS-1:0];
            end
            hsv_pkg::SECTOR_YELLOW_GREEN: begin
                px.red = lq[CHANNEL_BITS-1:0]; px.green = v[CHANNEL_BITS-1:0];
                px.blue = lp[CHANNEL_BITS-1:0];
            end
            hsv_pkg::SECTOR_GREEN_CYAN: begin
                px.red = lp[CHANNEL_BITS-1:0]; px.green = v[CHANNEL_BITS-1:0];
                px.blue = lt[CHANNEL_BITS-1:0];
            end
            hsv_pkg::SECTOR_CYAN_BLUE: begin
                px.red = lp[CHANNEL_BITS-1:0]; px.green = lq[CHANNEL_BITS-1:0];
                px.blue = v[CHANNEL_BITS-1:0];
            end
            hsv_pkg::SECTOR_BLUE_MAGENTA: begin
                px.red = lt[CHANNEL_BITS-1:0]; px.green = lp[CHANNEL_BITS-1:0];
                px.blue = v[CHANNEL_BITS-1:0];
            end
            default: begin
                px.red = v[CHANNEL_BITS-1:0];  px.green = lp[CHANNEL_BITS-1:0];
                px.blue = lq[CHANNEL_BITS-1:0];
            end
        endcase
        return px;
    endfunction

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    always @(posedge aclk) begin : watch
        rgb_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rgb.size() == 0) begin
                    $error("unexpected result transfer: red %0d green %0d blue %0d",
                           m_red, m_green, m_blue);
                    mismatch_count++;
                end else begin
                    want = expected_rgb.pop_front();
                    if (m_red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, m_red);
                        mismatch_count++;
                    end
                    if (m_green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, m_green);
                        mismatch_count++;
                    end
                    if (m_blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, m_blue);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_rgb.push_back(convert_pixel(s_hue, s_saturation, s_brightness));
            end
            pending_count = expected_rgb.size();
        end
    end

endmodule

FILE: tb/tb_hsv_to_rgb.sv
// Testbench top for the HSV to RGB converter: clock, reset, pixel stimulus and verdict.
module tb_hsv_to_rgb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_BITS      = 16;
    localparam int CHANNEL_BITS  = 8;
    localparam int PHASE_PIXELS  = 150;
    localparam int NUM_PHASES    = 4;
    localparam int MAX_WAIT      = 15;
    // The pipeline is five stages deep; the settle wait runs past that depth to show stray results.
    localparam int SETTLE_CYCLES = 10;

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic [HUE_BITS-1:0]     s_hue        = '0;
    logic [CHANNEL_BITS-1:0] s_saturation = '0;
    logic [CHANNEL_BITS-1:0] s_brightness = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic [CHANNEL_BITS-1:0] m_red;
    logic [CHANNEL_BITS-1:0] m_green;
    logic [CHANNEL_BITS-1:0] m_blue;

    int mismatch_count;
    int pending_count;
    int pixels_sent = 0;

    // When set, the sender or the receiver runs without idle cycles.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hsv_to_rgb #(
        .HUE_BITS    (HUE_BITS),
        .CHANNEL_BITS(CHANNEL_BITS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .s_saturation(s_saturation),
        .s_brightness(s_brightness),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue)
    );

    hsv_rgb_checker #(
        .HUE_BITS    (HUE_BITS),
        .CHANNEL_BITS(CHANNEL_BITS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hue         (s_hue),
        .s_saturation  (s_saturation),
        .s_brightness  (s_brightness),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    // Presents one pixel and holds it until the transfer happens. The task is entered and
    // left at a falling edge. Valid is left high on return, so that a following pixel with
    // no gap goes out back to back; every path assigns valid at most once per edge.
    task automatic send_pixel(input logic [HUE_BITS-1:0] hue,
                              input logic [CHANNEL_BITS-1:0] sat,
                              input logic [CHANNEL_BITS-1:0] bri);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_brightness <= bri;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Drops valid and holds the sender off until every predicted pixel has come back.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    // A level that lands on the extremes often enough to exercise grey, black and full scale.
    function automatic logic [CHANNEL_BITS-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CHANNEL_BITS'($urandom_range(1, 3));
            default: return CHANNEL_BITS'($urandom);
        endcase
    endfunction

    // Result side: before each result the receiver draws a stall, then holds ready high
    // until a transfer happens. In steady phases the stall is always zero.
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Main stimulus: reset, a directed set of pixels, then random phases that mix
    // idle and back-pressure patterns, with a full drain between phases.
    initial begin : stimulus
        logic [HUE_BITS-1:0] hue;
        int                  edge_idx;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pixels. Hue 10922/10923, 21845/21846, 43690/43691 and 54613/54614
        // straddle the sector edges; 32768 sits exactly on one, where the higher sector
        // takes over with a zero fraction. Zero saturation must give grey at any hue.
        send_pixel(16'd0,     8'd255, 8'd255);
        send_pixel(16'd0,     8'd0,   8'd200);
        send_pixel(16'd65535, 8'd0,   8'd255);
        send_pixel(16'd65535, 8'd255, 8'd255);
        send_pixel(16'd65535, 8'd1,   8'd1);
        send_pixel(16'd10922, 8'd255, 8'd255);
        send_pixel(16'd10923, 8'd255, 8'd255);
        send_pixel(16'd21845, 8'd128, 8'd255);
        send_pixel(16'd21846, 8'd128, 8'd255);
        send_pixel(16'd32767, 8'd255, 8'd255);
        send_pixel(16'd32768, 8'd255, 8'd255);
        send_pixel(16'd43690, 8'd200, 8'd100);
        send_pixel(16'd43691, 8'd200, 8'd100);
        send_pixel(16'd54613, 8'd255, 8'd128);
        send_pixel(16'd54614, 8'd255, 8'd128);
        send_pixel(16'd5461,  8'd255, 8'd0);
        send_pixel(16'd16384, 8'd1,   8'd255);
        send_pixel(16'd27306, 8'd254, 8'd254);
        send_pixel(16'd38229, 8'd170, 8'd85);
        send_pixel(16'd49152, 8'd127, 8'd255);
        send_pixel(16'd60074, 8'd255, 8'd1);
        send_pixel(16'd65535, 8'd255, 8'd0);
        pause_until_drained();

        // Phase 0 idles on both sides, phase 1 on neither, phase 2 only stalls the
        // receiver (back-pressure with a full pipeline), phase 3 only gaps the sender.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            tx_steady = (phase == 1) || (phase == 2);
            rx_steady = (phase == 1) || (phase == 3);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                // A quarter of the hues fall within a few codes of a sector edge.
                if ($urandom_range(0, 3) == 0) begin
                    edge_idx = $urandom_range(1, 5);
                    hue = HUE_BITS'((edge_idx * 65536 + 5) / 6 + $urandom_range(0, 4) - 2);
                end else begin
                    hue = HUE_BITS'($urandom);
                end
                send_pixel(hue, pick_level(), pick_level());
            end
            pause_until_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Sent %0d pixels: sector edges, grey and extreme levels, then random hues",
                 pixels_sent);
        $display("under four mixes of sender gaps and receiver stalls, draining between them.");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // The slowest correct run needs about a tenth of this.
    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
